// File: rtl/assert_macros.svh
// Assertion macros used by the RTL checker top level.
// Depends on nothing; the using module supplies clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge out of reset.
`define AST_HOLD(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);
// Same-cycle implication.
`define AST_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication.
`define AST_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define AST_HOLD(label, expr, msg)
`define AST_IMPL(label, ante, cons, msg)
`define AST_NEXT(label, ante, cons, msg)
`endif
`endif

// File: rtl/ihc_pkg.sv
// Shared types and constants for the IPv4 header checker.
// No dependencies.
`default_nettype none
package ihc_pkg;
	localparam int COUNTER_WIDTH_DEF = 32;
	localparam int SUM_W             = 21;
	localparam int OUT_W             = 144;   // 139 payload bits, padded to bytes

	localparam logic [15:0] MIN_HDR_BYTES = 16'd20;
	localparam logic [15:0] COUNT_MAX     = 16'hFFFF;
	localparam logic [15:0] FRAG_OFF_MASK = 16'h1FFF;
	localparam logic [15:0] HALF_MASK     = 16'hFFFF;
	localparam logic [3:0]  VERSION_IPV4  = 4'd4;
	localparam logic [3:0]  IHL_MIN       = 4'd5;
	localparam int          MF_BIT        = 13;

	typedef enum logic [2:0] {
		V_ACCEPT   = 3'd0,
		V_SHORT    = 3'd1,
		V_VERSION  = 3'd2,
		V_HDRLEN   = 3'd3,
		V_LENGTH   = 3'd4,
		V_FRAG     = 3'd5,
		V_CHECKSUM = 3'd6
	} verdict_t;

	// Per-packet header state
	typedef struct packed {
		logic [15:0]      count;
		logic [7:0]       ver_ihl;
		logic [15:0]      tot_len;
		logic [15:0]      frag_word;
		logic [7:0]       proto;
		logic [31:0]      src;
		logic [31:0]      dst;
		logic [7:0]       high;
		logic [SUM_W-1:0] sum;
	} hdr_t;
endpackage
`default_nettype wire

// File: rtl/ihc_hdr_capture.sv
// Per-packet header capture and header word sum.
// Depends on ihc_pkg.
`default_nettype none
module ihc_hdr_capture (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        adv,        // byte in stage 1 is consumed
	input  wire logic        last,
	input  wire logic [7:0]  data_byte,
	output ihc_pkg::hdr_t    hdr_nxt     // state including this byte
);
	localparam logic [15:0] IDX_VER   = 16'd0;
	localparam logic [15:0] IDX_LEN_H = 16'd2;
	localparam logic [15:0] IDX_LEN_L = 16'd3;
	localparam logic [15:0] IDX_FRG_H = 16'd6;
	localparam logic [15:0] IDX_FRG_L = 16'd7;
	localparam logic [15:0] IDX_PROTO = 16'd9;

	ihc_pkg::hdr_t hdr_q;
	logic [15:0]   idx;
	logic [7:0]    ver_nxt;
	logic [15:0]   hdr_bytes;

	assign idx       = hdr_q.count;
	assign ver_nxt   = (idx == IDX_VER) ? data_byte : hdr_q.ver_ihl;
	assign hdr_bytes = {10'd0, ver_nxt[3:0], 2'b00};

	always_comb begin
		hdr_nxt = hdr_q;
		if (hdr_q.count != ihc_pkg::COUNT_MAX) begin
			hdr_nxt.count = hdr_q.count + 16'd1;
		end
		if (idx == IDX_VER) begin
			hdr_nxt.ver_ihl = data_byte;
		end else if (idx == IDX_LEN_H || idx == IDX_LEN_L) begin
			hdr_nxt.tot_len = {hdr_q.tot_len[7:0], data_byte};
		end else if (idx == IDX_FRG_H || idx == IDX_FRG_L) begin
			hdr_nxt.frag_word = {hdr_q.frag_word[7:0], data_byte};
		end else if (idx == IDX_PROTO) begin
			hdr_nxt.proto = data_byte;
		end else if (idx inside {[16'd12:16'd15]}) begin
			hdr_nxt.src = {hdr_q.src[23:0], data_byte};
		end else if (idx inside {[16'd16:16'd19]}) begin
			hdr_nxt.dst = {hdr_q.dst[23:0], data_byte};
		end
		// header words: IHL taken after this byte's capture
		if (idx < hdr_bytes) begin
			if (!idx[0]) begin
				hdr_nxt.high = data_byte;
			end else begin
				hdr_nxt.sum = hdr_q.sum + ihc_pkg::SUM_W'({hdr_q.high, data_byte});
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q <= '0;
		end else if (adv) begin
			hdr_q <= last ? '0 : hdr_nxt;
		end
	end
endmodule
`default_nettype wire

// File: rtl/ihc_judge.sv
// Verdict logic: ordered header checks on the final packet state.
// Depends on ihc_pkg.
`default_nettype none
module ihc_judge (
	input  wire ihc_pkg::hdr_t hdr,
	output ihc_pkg::verdict_t verdict
);
	logic [3:0]  ihl;
	logic [16:0] fold1;
	logic [16:0] fold2;
	logic [15:0] hdr_bytes;

	assign ihl       = hdr.ver_ihl[3:0];
	assign hdr_bytes = {10'd0, ihl, 2'b00};
	// ones'-complement fold of the 21-bit sum, twice
	assign fold1 = {1'b0, hdr.sum[15:0]} + 17'(hdr.sum[ihc_pkg::SUM_W-1:16]);
	assign fold2 = {1'b0, fold1[15:0]} + 17'(fold1[16]);

	always_comb begin
		if (hdr.count < ihc_pkg::MIN_HDR_BYTES) begin
			verdict = ihc_pkg::V_SHORT;
		end else if (hdr.ver_ihl[7:4] != ihc_pkg::VERSION_IPV4) begin
			verdict = ihc_pkg::V_VERSION;
		end else if (ihl < ihc_pkg::IHL_MIN || hdr.count < hdr_bytes) begin
			verdict = ihc_pkg::V_HDRLEN;
		end else if (hdr.tot_len > hdr.count) begin
			verdict = ihc_pkg::V_LENGTH;
		end else if ((hdr.frag_word & ihc_pkg::FRAG_OFF_MASK) != 16'd0
			|| hdr.frag_word[ihc_pkg::MF_BIT]) begin
			verdict = ihc_pkg::V_FRAG;
		end else if (fold2 != {1'b0, ihc_pkg::HALF_MASK}) begin
			verdict = ihc_pkg::V_CHECKSUM;
		end else begin
			verdict = ihc_pkg::V_ACCEPT;
		end
	end
endmodule
`default_nettype wire

// File: rtl/ipv4_header_checker_core.sv
// IPv4 header checker top level: input register, capture, verdict, result register.
// Depends on ihc_pkg, ihc_hdr_capture, ihc_judge and assert_macros.svh.
//
// Takes an IPv4 packet one byte per beat on the slave side (tlast on the
// final byte) and gives one result beat per packet on the master side.
// Throughput is one byte per clock unless a last byte is held: each byte
// passes through the input register, where the header capture and the
// 16-bit word add are done, and on the last byte the ordered checks run in
// that same cycle and the result register is loaded. A last byte, and the
// input behind it, waits while the result register is full and stalled;
// other bytes flow regardless of master-side backpressure. Verdict codes:
// 0 accept, 1 too short, 2 bad version, 3 bad header length, 4 length
// mismatch, 5 fragmented, 6 bad checksum. On a rejection the protocol and
// address fields read zero. The accepted and rejected totals are
// COUNTER_WIDTH bits wide and wrap; the result shows their low 32 bits
// (zero-extended when narrower), this packet included.
`default_nettype none
`include "assert_macros.svh"
module ipv4_header_checker_core #(
	parameter int COUNTER_WIDTH = ihc_pkg::COUNTER_WIDTH_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      s_axis_tvalid,
	output logic                           s_axis_tready,
	input  wire logic [7:0]                s_axis_tdata,   // [7:0] data_byte
	input  wire logic                      s_axis_tlast,   // last_byte
	output logic                           m_axis_tvalid,
	input  wire logic                      m_axis_tready,
	// [2:0] verdict, [10:3] protocol_number, [42:11] source_address,
	// [74:43] destination_address, [106:75] accepted_count,
	// [138:107] rejected_count, [143:139] zero
	output logic [ihc_pkg::OUT_W-1:0]      m_axis_tdata
);
	// input register
	logic                      byte_vld_s1;
	logic [7:0]                byte_s1;
	logic                      last_s1;
	// result register
	logic                      out_vld_q;
	logic [ihc_pkg::OUT_W-1:0] out_data_q;
	// totals
	logic [COUNTER_WIDTH-1:0]  acc_q;
	logic [COUNTER_WIDTH-1:0]  rej_q;
	logic [COUNTER_WIDTH-1:0]  acc_nxt;
	logic [COUNTER_WIDTH-1:0]  rej_nxt;

	logic              adv;
	logic              load_out;
	logic              accept;
	ihc_pkg::hdr_t     hdr_nxt;
	ihc_pkg::verdict_t verdict;

	// A byte leaves stage 1 unless it is a last byte facing a full, stalled result.
	assign adv           = byte_vld_s1 && (!last_s1 || !out_vld_q || m_axis_tready);
	assign load_out      = adv && last_s1;
	assign s_axis_tready = !byte_vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			byte_vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	ihc_hdr_capture u_capture (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.last      (last_s1),
		.data_byte (byte_s1),
		.hdr_nxt   (hdr_nxt)
	);

	ihc_judge u_judge (
		.hdr     (hdr_nxt),
		.verdict (verdict)
	);

	assign accept  = (verdict == ihc_pkg::V_ACCEPT);
	assign acc_nxt = accept ? acc_q + COUNTER_WIDTH'(1) : acc_q;
	assign rej_nxt = accept ? rej_q : rej_q + COUNTER_WIDTH'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			rej_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (load_out) begin
				acc_q     <= acc_nxt;
				rej_q     <= rej_nxt;
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// result beat payload; rejected packets expose no header fields
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q <= {5'd0,
				32'(rej_nxt),
				32'(acc_nxt),
				accept ? hdr_nxt.dst : 32'd0,
				accept ? hdr_nxt.src : 32'd0,
				accept ? hdr_nxt.proto : 8'd0,
				verdict};
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;

	`AST_HOLD(a_no_overwrite, !(load_out && out_vld_q && !m_axis_tready),
		"result register overwritten while stalled")
	`AST_IMPL(a_last_held, byte_vld_s1 && last_s1 && out_vld_q && !m_axis_tready,
		!s_axis_tready, "input taken while last byte is blocked")
	`AST_NEXT(a_one_total, load_out,
		(acc_q != $past(acc_q)) != (rej_q != $past(rej_q)),
		"packet must bump exactly one total")
	`AST_IMPL(a_reject_zero, out_vld_q && out_data_q[2:0] != ihc_pkg::V_ACCEPT,
		out_data_q[74:3] == 72'd0, "rejected result carries header fields")
endmodule
`default_nettype wire
